// ===== src/gmdfs_pkg.sv =====
`timescale 1ns / 1ps

package gmdfs_pkg;

    // Grid and stack geometry
    localparam int GRID_SIZE   = 16;
    localparam int STACK_DEPTH = 256;
    localparam int CELL_COUNT  = GRID_SIZE * GRID_SIZE;
    localparam int CELL_AW     = $clog2(CELL_COUNT);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    // Field widths
    localparam int COORD_W   = 4;
    localparam int POS_W     = COORD_W + 2;
    localparam int OP_W      = 2;
    localparam int STEP_W    = 8;
    localparam int LEN_W     = 9;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        CELL_WALL = 2'd0,
        CELL_OPEN = 2'd1,
        CELL_SEEN = 2'd2
    } cell_t;

    // Search order: row+1, col+1, row-1, col-1
    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_SOLVE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ROW = 2'd0,
        CFG_START_COL = 2'd1,
        CFG_GOAL_ROW  = 2'd2,
        CFG_GOAL_COL  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_EVAL,
        ST_POP
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        dir_t               dir;
    } stack_entry_t;

    typedef struct packed {
        logic               wr_en;
        logic [CELL_AW-1:0] wr_addr;
        cell_t              wr_data;
        logic [CELL_AW-1:0] rd_addr;
    } map_req_t;

    typedef struct packed {
        logic                wr_en;
        logic [STACK_AW-1:0] wr_addr;
        stack_entry_t        wr_data;
        logic [STACK_AW-1:0] rd_addr;
    } stack_req_t;

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                     input logic [COORD_W-1:0] col);
        return CELL_AW'(int'(row) * GRID_SIZE + int'(col));
    endfunction

    function automatic dir_t step_dir(input dir_t dir);
        dir_t result;
        case (dir)
            DIR_DOWN:  result = DIR_RIGHT;
            DIR_RIGHT: result = DIR_UP;
            DIR_UP:    result = DIR_LEFT;
            default:   result = DIR_LEFT;
        endcase
        return result;
    endfunction

endpackage

// ===== src/gmdfs_cell_map.sv =====
`timescale 1ns / 1ps

module gmdfs_cell_map
    import gmdfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  map_req_t req,
    output cell_t    rd_cell
);

    cell_t                 mem [CELL_COUNT];
    logic [CELL_COUNT-1:0] valid_reg;
    cell_t                 rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    // A cell never written reads as wall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rd_cell = rd_valid_reg ? rd_data_reg : CELL_WALL;

endmodule

// ===== src/gmdfs_path_stack.sv =====
`timescale 1ns / 1ps

module gmdfs_path_stack
    import gmdfs_pkg::*;
(
    input  logic         clk,
    input  stack_req_t   req,
    output stack_entry_t rd_entry
);

    stack_entry_t mem [STACK_DEPTH];
    stack_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_entry = rd_data_reg;

endmodule

// ===== src/grid_maze_dfs_path_core.sv =====
`timescale 1ns / 1ps
// Timing: a cell write or an unused operation gives its result via the result register, a path
// read via the ST_READ state and then the result register. A solve spends ST_CHECK and ST_EVAL
// per probed cell and ST_POP per popped entry, then the result register (synchronous reads).
// Throughput: one write per cycle; busy holds off items during a path read or a solve.
// The receiver cannot stall: done marks each result for exactly one cycle.
// Reset: control and config registers reset; the map reads as all wall via per-cell valid flags.

module grid_maze_dfs_path_core
    import gmdfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    // Item command
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      operation,
    input  logic [COORD_W-1:0]   cell_row,
    input  logic [COORD_W-1:0]   cell_col,
    input  logic                 cell_open,
    input  logic [STEP_W-1:0]    step_index,

    // Result strobe and fields
    output logic                 done,
    output logic                 found,
    output logic [LEN_W-1:0]     path_length,
    output logic [COORD_W-1:0]   path_row,
    output logic [COORD_W-1:0]   path_col
);

    // Configuration registers
    logic [COORD_W-1:0] start_row_reg;
    logic [COORD_W-1:0] start_col_reg;
    logic [COORD_W-1:0] goal_row_reg;
    logic [COORD_W-1:0] goal_col_reg;

    // Control state
    state_t             state_reg;
    state_t             state_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               last_found_reg;
    logic               last_found_next;
    logic [POS_W-1:0]   cand_row_reg;
    logic [POS_W-1:0]   cand_row_next;
    logic [POS_W-1:0]   cand_col_reg;
    logic [POS_W-1:0]   cand_col_next;
    logic               read_hit_reg;
    logic               read_hit_next;

    // Result registers
    logic               done_reg;
    logic               done_next;
    logic               found_reg;
    logic               found_next;
    logic [LEN_W-1:0]   path_length_reg;
    logic [LEN_W-1:0]   path_length_next;
    logic [COORD_W-1:0] path_row_reg;
    logic [COORD_W-1:0] path_row_next;
    logic [COORD_W-1:0] path_col_reg;
    logic [COORD_W-1:0] path_col_next;

    // Memory ports
    map_req_t     map_req;
    cell_t        map_rd_cell;
    stack_req_t   stack_req;
    stack_entry_t stack_rd_entry;

    // Decision terms
    logic               accept;
    logic               cand_on_grid;
    logic               cand_open;
    logic               stack_full;
    logic               depth_zero;
    logic               goal_hit;
    logic               pop_exhausted;
    logic [DEPTH_W-1:0] depth_dec;
    dir_t               pop_dir;
    logic [POS_W-1:0]   pop_row_ext;
    logic [POS_W-1:0]   pop_col_ext;

    gmdfs_cell_map u_cell_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .rd_cell (map_rd_cell)
    );

    gmdfs_path_stack u_path_stack (
        .clk      (clk),
        .req      (stack_req),
        .rd_entry (stack_rd_entry)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // A candidate off the grid is a wall; the map read for it is ignored
    assign cand_on_grid = !cand_row_reg[POS_W-1] && (cand_row_reg < POS_W'(GRID_SIZE))
                       && !cand_col_reg[POS_W-1] && (cand_col_reg < POS_W'(GRID_SIZE));
    assign cand_open    = cand_on_grid && (map_rd_cell == CELL_OPEN);
    assign stack_full   = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign depth_zero   = (depth_reg == '0);
    assign depth_dec    = depth_reg - DEPTH_W'(1);
    assign goal_hit     = (cand_row_reg == {2'b00, goal_row_reg})
                       && (cand_col_reg == {2'b00, goal_col_reg});

    // Entry just popped: all four directions tried means it is exhausted
    assign pop_exhausted = (stack_rd_entry.dir == DIR_LEFT);
    assign pop_dir       = step_dir(stack_rd_entry.dir);
    assign pop_row_ext   = {2'b00, stack_rd_entry.row};
    assign pop_col_ext   = {2'b00, stack_rd_entry.col};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg <= '0;
            start_col_reg <= '0;
            goal_row_reg  <= COORD_W'(GRID_SIZE - 1);
            goal_col_reg  <= COORD_W'(GRID_SIZE - 1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_ROW: start_row_reg <= cfg_data;
                CFG_START_COL: start_col_reg <= cfg_data;
                CFG_GOAL_ROW:  goal_row_reg  <= cfg_data;
                CFG_GOAL_COL:  goal_col_reg  <= cfg_data;
                default:       start_row_reg <= start_row_reg;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_SOLVE: state_next = ST_CHECK;
                        OP_READ:  state_next = ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:  state_next = ST_IDLE;
            ST_CHECK: state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (cand_open && !stack_full)
                begin
                    state_next = goal_hit ? ST_IDLE : ST_CHECK;
                end
                else if (!depth_zero)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (!pop_exhausted)
                begin
                    state_next = ST_CHECK;
                end
                else if (!depth_zero)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory requests and results
    always_comb
    begin
        depth_next       = depth_reg;
        last_found_next  = last_found_reg;
        cand_row_next    = cand_row_reg;
        cand_col_next    = cand_col_reg;
        read_hit_next    = read_hit_reg;

        done_next        = 1'b0;
        found_next       = found_reg;
        path_length_next = path_length_reg;
        path_row_next    = path_row_reg;
        path_col_next    = path_col_reg;

        map_req.wr_en    = 1'b0;
        map_req.wr_addr  = cell_addr(cell_row, cell_col);
        map_req.wr_data  = cell_open ? CELL_OPEN : CELL_WALL;
        map_req.rd_addr  = cell_addr(cand_row_reg[COORD_W-1:0], cand_col_reg[COORD_W-1:0]);

        stack_req.wr_en       = 1'b0;
        stack_req.wr_addr     = depth_reg[STACK_AW-1:0];
        stack_req.wr_data.row = cand_row_reg[COORD_W-1:0];
        stack_req.wr_data.col = cand_col_reg[COORD_W-1:0];
        stack_req.wr_data.dir = DIR_DOWN;
        stack_req.rd_addr     = depth_dec[STACK_AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                stack_req.rd_addr = STACK_AW'(step_index);
                if (accept)
                begin
                    case (operation)
                        OP_WRITE:
                        begin
                            // Drop writes that fall outside the grid
                            map_req.wr_en = (int'(cell_row) < GRID_SIZE)
                                         && (int'(cell_col) < GRID_SIZE);
                            done_next        = 1'b1;
                            found_next       = 1'b0;
                            path_length_next = '0;
                            path_row_next    = '0;
                            path_col_next    = '0;
                        end
                        OP_SOLVE:
                        begin
                            depth_next      = '0;
                            last_found_next = 1'b0;
                            cand_row_next   = {2'b00, start_row_reg};
                            cand_col_next   = {2'b00, start_col_reg};
                        end
                        OP_READ:
                        begin
                            read_hit_next = (DEPTH_W'(step_index) < depth_reg);
                        end
                        default:
                        begin
                            done_next        = 1'b1;
                            found_next       = 1'b0;
                            path_length_next = '0;
                            path_row_next    = '0;
                            path_col_next    = '0;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                done_next        = 1'b1;
                found_next       = last_found_reg;
                path_length_next = LEN_W'(depth_reg);
                path_row_next    = read_hit_reg ? stack_rd_entry.row : '0;
                path_col_next    = read_hit_reg ? stack_rd_entry.col : '0;
            end

            ST_EVAL:
            begin
                if (cand_open && !stack_full)
                begin
                    // Enter the cell: mark it visited and push it
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = cell_addr(cand_row_reg[COORD_W-1:0],
                                                cand_col_reg[COORD_W-1:0]);
                    map_req.wr_data = CELL_SEEN;
                    stack_req.wr_en = 1'b1;
                    depth_next      = depth_reg + DEPTH_W'(1);
                    cand_row_next   = cand_row_reg + POS_W'(1);
                    if (goal_hit)
                    begin
                        last_found_next  = 1'b1;
                        done_next        = 1'b1;
                        found_next       = 1'b1;
                        path_length_next = LEN_W'(depth_reg + DEPTH_W'(1));
                        path_row_next    = '0;
                        path_col_next    = '0;
                    end
                end
                else if (!depth_zero)
                begin
                    // Blocked: pop the top entry, read data arrives next cycle
                    depth_next = depth_dec;
                end
                else
                begin
                    done_next        = 1'b1;
                    found_next       = 1'b0;
                    path_length_next = '0;
                    path_row_next    = '0;
                    path_col_next    = '0;
                end
            end

            ST_POP:
            begin
                if (!pop_exhausted)
                begin
                    // Advance to the next direction and push the entry back
                    stack_req.wr_en       = 1'b1;
                    stack_req.wr_data.row = stack_rd_entry.row;
                    stack_req.wr_data.col = stack_rd_entry.col;
                    stack_req.wr_data.dir = pop_dir;
                    depth_next            = depth_reg + DEPTH_W'(1);
                    cand_row_next         = pop_row_ext;
                    cand_col_next         = pop_col_ext;
                    case (pop_dir)
                        DIR_DOWN:  cand_row_next = pop_row_ext + POS_W'(1);
                        DIR_RIGHT: cand_col_next = pop_col_ext + POS_W'(1);
                        DIR_UP:    cand_row_next = pop_row_ext - POS_W'(1);
                        default:   cand_col_next = pop_col_ext - POS_W'(1);
                    endcase
                end
                else if (!depth_zero)
                begin
                    // Exhausted: wall it off and pop the one below
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = cell_addr(stack_rd_entry.row, stack_rd_entry.col);
                    map_req.wr_data = CELL_WALL;
                    depth_next      = depth_dec;
                end
                else
                begin
                    // Bottom entry exhausted: it stays visited, no path
                    done_next        = 1'b1;
                    found_next       = 1'b0;
                    path_length_next = '0;
                    path_row_next    = '0;
                    path_col_next    = '0;
                end
            end

            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            depth_reg      <= '0;
            last_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            depth_reg      <= depth_next;
            last_found_reg <= last_found_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cand_row_reg    <= cand_row_next;
        cand_col_reg    <= cand_col_next;
        read_hit_reg    <= read_hit_next;
        found_reg       <= found_next;
        path_length_reg <= path_length_next;
        path_row_reg    <= path_row_next;
        path_col_reg    <= path_col_next;
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign path_length = path_length_reg;
    assign path_row    = path_row_reg;
    assign path_col    = path_col_reg;

    // Checks
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("path stack depth beyond capacity");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (done_reg && (state_reg == ST_IDLE)))
        else $error("path read did not return its item");

    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == OP_SOLVE)) |=> (busy && !done_reg))
        else $error("solve item did not start the search");

    a_found_length: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg && (state_reg == ST_IDLE) && $past(state_reg == ST_EVAL))
            |-> (path_length_reg != '0))
        else $error("goal reached with an empty path");

endmodule
